// File: rtl/esge_pkg.sv
`timescale 1ns / 1ps

package esge_pkg;

   typedef logic [2:0] state_type;
   typedef logic [3:0] func_type;

   localparam state_type ST_S0 = 3'd0;
   localparam state_type ST_S1 = 3'd1;
   localparam state_type ST_W0 = 3'd2;
   localparam state_type ST_W1 = 3'd3;
   localparam state_type ST_Z  = 3'd4;
   localparam state_type ST_X  = 3'd5;
   localparam state_type ST_SX = 3'd6;
   localparam state_type ST_WX = 3'd7;

   localparam func_type FN_RESOLVE    = 4'd0;
   localparam func_type FN_AND        = 4'd1;
   localparam func_type FN_OR         = 4'd2;
   localparam func_type FN_XOR        = 4'd3;
   localparam func_type FN_NAND       = 4'd4;
   localparam func_type FN_NOR        = 4'd5;
   localparam func_type FN_XNOR       = 4'd6;
   localparam func_type FN_NOT        = 4'd7;
   localparam func_type FN_BUF        = 4'd8;
   localparam func_type FN_WEAKPULL   = 4'd9;
   localparam func_type FN_WEAKPULLDN = 4'd10;
   localparam func_type FN_STRONGPULL = 4'd11;
   localparam func_type FN_VCC        = 4'd12;
   localparam func_type FN_GND        = 4'd13;
   localparam func_type FN_TRISTATE   = 4'd14;

endpackage

// File: rtl/esge_if.sv
`timescale 1ns / 1ps

interface esge_req_if import esge_pkg::*; ();
   logic      valid;
   logic      ready;
   func_type  func;
   state_type operand_a;
   state_type operand_b;

   modport source (output valid, output func, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input func, input operand_a, input operand_b,
                   output ready);
endinterface

interface esge_rsp_if import esge_pkg::*; ();
   logic      valid;
   logic      ready;
   state_type result_state;

   modport source (output valid, output result_state, input ready);
   modport sink   (input valid, input result_state, output ready);
endinterface

// File: rtl/eight_state_logic_gate_evaluator.sv
`timescale 1ns / 1ps
// An accepted request word passes the input register and then the result register.
// Throughput is one word per cycle while rsp_ch.ready holds, set by the input
// register and the result register, with ready passed back through both stages.
// Synchronous reset clears both valid flags; the payload registers are not reset.

module eight_state_logic_gate_evaluator import esge_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   esge_req_if.sink          req_ch,
   esge_rsp_if.source        rsp_ch
);

   logic      in_valid_ff;
   logic      in_valid_in;
   func_type  func_ff;
   state_type operand_a_ff;
   state_type operand_b_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   state_type result_ff;
   state_type result_in;
   logic      out_load;
   logic      in_load;

   assign out_load = !out_valid_ff || rsp_ch.ready;
   assign in_load  = !in_valid_ff || out_load;

   assign req_ch.ready        = in_load;
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_state = result_ff;

   assign in_valid_in  = in_load ? req_ch.valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   esge_eval u_eval (
      .func         (func_ff),
      .operand_a    (operand_a_ff),
      .operand_b    (operand_b_ff),
      .result_state (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_ch.valid) begin
         func_ff      <= req_ch.func;
         operand_a_ff <= req_ch.operand_a;
         operand_b_ff <= req_ch.operand_b;
      end
      if (out_load && in_valid_ff) begin
         result_ff <= result_in;
      end
   end

endmodule

// File: rtl/esge_eval.sv
`timescale 1ns / 1ps

module esge_eval import esge_pkg::*; (
   input  func_type  func,
   input  state_type operand_a,
   input  state_type operand_b,
   output state_type result_state
);

   localparam state_type CONT_TAB [0:7][0:7] = '{
      '{ST_S0, ST_SX, ST_S0, ST_S0, ST_S0, ST_SX, ST_SX, ST_S0},
      '{ST_SX, ST_S1, ST_S1, ST_S1, ST_S1, ST_SX, ST_SX, ST_S1},
      '{ST_S0, ST_S1, ST_W0, ST_WX, ST_W0, ST_X,  ST_SX, ST_WX},
      '{ST_S0, ST_S1, ST_WX, ST_W1, ST_W1, ST_X,  ST_SX, ST_WX},
      '{ST_S0, ST_S1, ST_W0, ST_W1, ST_Z,  ST_X,  ST_SX, ST_WX},
      '{ST_SX, ST_SX, ST_X,  ST_X,  ST_X,  ST_X,  ST_SX, ST_X },
      '{ST_SX, ST_SX, ST_SX, ST_SX, ST_SX, ST_SX, ST_SX, ST_SX},
      '{ST_S0, ST_S1, ST_WX, ST_WX, ST_WX, ST_X,  ST_SX, ST_WX}
   };
   localparam state_type INV_TAB   [0:7] =
      '{ST_S1, ST_S0, ST_W1, ST_W0, ST_Z,  ST_X,  ST_SX, ST_WX};
   localparam state_type WPULL_TAB [0:7] =
      '{ST_W0, ST_W1, ST_W0, ST_W1, ST_W1, ST_WX, ST_SX, ST_WX};
   localparam state_type SPULL_TAB [0:7] =
      '{ST_S0, ST_S1, ST_S0, ST_S1, ST_S1, ST_SX, ST_SX, ST_SX};

   state_type table_val;
   state_type and_val;
   state_type or_val;
   state_type xor_val;
   state_type tri_val;
   logic      a_bin;
   logic      b_bin;

   assign table_val = CONT_TAB[operand_a][operand_b];
   assign a_bin = (operand_a == ST_S0) || (operand_a == ST_S1);
   assign b_bin = (operand_b == ST_S0) || (operand_b == ST_S1);

   always_comb begin
      if (a_bin && b_bin) begin
         and_val = (operand_a == ST_S1 && operand_b == ST_S1) ? ST_S1 : ST_S0;
      end else if (operand_a == ST_S0 || operand_b == ST_S0) begin
         and_val = ST_S0;
      end else begin
         and_val = table_val;
      end

      if (a_bin && b_bin) begin
         or_val = (operand_a == ST_S1 || operand_b == ST_S1) ? ST_S1 : ST_S0;
      end else if (operand_a == ST_S1 || operand_b == ST_S1) begin
         or_val = ST_S1;
      end else begin
         or_val = table_val;
      end

      if (a_bin && b_bin) begin
         xor_val = (operand_a != operand_b) ? ST_S1 : ST_S0;
      end else if (operand_a == ST_SX || operand_b == ST_SX) begin
         xor_val = ST_SX;
      end else if (operand_a == ST_X || operand_b == ST_X ||
                   operand_a == ST_Z || operand_b == ST_Z) begin
         xor_val = ST_X;
      end else begin
         xor_val = table_val;
      end

      unique case (operand_b)
         ST_S1, ST_W1:        tri_val = operand_a;
         ST_S0, ST_W0, ST_Z:  tri_val = ST_Z;
         ST_SX:               tri_val = ST_SX;
         default:             tri_val = ST_X;
      endcase
   end

   always_comb begin
      unique case (func)
         FN_RESOLVE:    result_state = table_val;
         FN_AND:        result_state = and_val;
         FN_OR:         result_state = or_val;
         FN_XOR:        result_state = xor_val;
         FN_NAND:       result_state = INV_TAB[and_val];
         FN_NOR:        result_state = INV_TAB[or_val];
         FN_XNOR:       result_state = INV_TAB[xor_val];
         FN_NOT:        result_state = INV_TAB[operand_a];
         FN_BUF:        result_state = operand_a;
         FN_WEAKPULL:   result_state = WPULL_TAB[operand_a];
         FN_WEAKPULLDN: result_state = INV_TAB[WPULL_TAB[INV_TAB[operand_a]]];
         FN_STRONGPULL: result_state = SPULL_TAB[operand_a];
         FN_VCC:        result_state = ST_S1;
         FN_GND:        result_state = ST_S0;
         FN_TRISTATE:   result_state = tri_val;
         default:       result_state = ST_X;
      endcase
   end

endmodule

// File: verif/tb_eight_state_logic_gate_evaluator.sv
`timescale 1ns / 1ps

module tb_eight_state_logic_gate_evaluator;
   import esge_pkg::*;

   localparam func_type FN_UNUSED = 4'd15;
   localparam int RANDOM_WORDS = 1700;
   localparam int IDLE_PERCENT = 8;

   class gate_result_tracker;
      state_type   pending_states[$];
      int unsigned failures;

      function bit is_binary(state_type s);
         return s == ST_S0 || s == ST_S1;
      endfunction

      function state_type contend(state_type a, state_type b);
         state_type row[8];
         case (a)
            ST_S0: row = '{ST_S0, ST_SX, ST_S0, ST_S0, ST_S0, ST_SX, ST_SX, ST_S0};
            ST_S1: row = '{ST_SX, ST_S1, ST_S1, ST_S1, ST_S1, ST_SX, ST_SX, ST_S1};
            ST_W0: row = '{ST_S0, ST_S1, ST_W0, ST_WX, ST_W0, ST_X,  ST_SX, ST_WX};
            ST_W1: row = '{ST_S0, ST_S1, ST_WX, ST_W1, ST_W1, ST_X,  ST_SX, ST_WX};
            ST_Z:  row = '{ST_S0, ST_S1, ST_W0, ST_W1, ST_Z,  ST_X,  ST_SX, ST_WX};
            ST_X:  row = '{ST_SX, ST_SX, ST_X,  ST_X,  ST_X,  ST_X,  ST_SX, ST_X};
            ST_SX: row = '{ST_SX, ST_SX, ST_SX, ST_SX, ST_SX, ST_SX, ST_SX, ST_SX};
            default: row = '{ST_S0, ST_S1, ST_WX, ST_WX, ST_WX, ST_X,  ST_SX, ST_WX};
         endcase
         return row[b];
      endfunction

      function state_type invert(state_type s);
         case (s)
            ST_S0: return ST_S1;
            ST_S1: return ST_S0;
            ST_W0: return ST_W1;
            ST_W1: return ST_W0;
            default: return s;
         endcase
      endfunction

      function state_type weak_pull(state_type s);
         case (s)
            ST_S0, ST_W0: return ST_W0;
            ST_S1, ST_W1, ST_Z: return ST_W1;
            ST_SX: return ST_SX;
            default: return ST_WX;
         endcase
      endfunction

      function state_type strong_pull(state_type s);
         case (s)
            ST_S0, ST_W0: return ST_S0;
            ST_S1, ST_W1, ST_Z: return ST_S1;
            default: return ST_SX;
         endcase
      endfunction

      function state_type gate_and(state_type a, state_type b);
         if (is_binary(a) && is_binary(b)) begin
            return (a == ST_S1 && b == ST_S1) ? ST_S1 : ST_S0;
         end
         if (a == ST_S0 || b == ST_S0) begin
            return ST_S0;
         end
         return contend(a, b);
      endfunction

      function state_type gate_or(state_type a, state_type b);
         if (is_binary(a) && is_binary(b)) begin
            return (a == ST_S1 || b == ST_S1) ? ST_S1 : ST_S0;
         end
         if (a == ST_S1 || b == ST_S1) begin
            return ST_S1;
         end
         return contend(a, b);
      endfunction

      function state_type gate_xor(state_type a, state_type b);
         if (is_binary(a) && is_binary(b)) begin
            return (a != b) ? ST_S1 : ST_S0;
         end
         if (a == ST_SX || b == ST_SX) begin
            return ST_SX;
         end
         if (a == ST_X || b == ST_X || a == ST_Z || b == ST_Z) begin
            return ST_X;
         end
         return contend(a, b);
      endfunction

      function state_type predict_state(func_type f, state_type a, state_type b);
         state_type r;
         case (f)
            FN_RESOLVE:    r = contend(a, b);
            FN_AND:        r = gate_and(a, b);
            FN_OR:         r = gate_or(a, b);
            FN_XOR:        r = gate_xor(a, b);
            FN_NAND:       r = invert(gate_and(a, b));
            FN_NOR:        r = invert(gate_or(a, b));
            FN_XNOR:       r = invert(gate_xor(a, b));
            FN_NOT:        r = invert(a);
            FN_BUF:        r = a;
            FN_WEAKPULL:   r = weak_pull(a);
            FN_WEAKPULLDN: r = invert(weak_pull(invert(a)));
            FN_STRONGPULL: r = strong_pull(a);
            FN_VCC:        r = ST_S1;
            FN_GND:        r = ST_S0;
            FN_TRISTATE: begin
               case (b)
                  ST_S1, ST_W1: r = a;
                  ST_S0, ST_W0, ST_Z: r = ST_Z;
                  ST_SX: r = ST_SX;
                  default: r = ST_X;
               endcase
            end
            default:       r = ST_X;
         endcase
         return r;
      endfunction

      function void note_request(func_type f, state_type a, state_type b);
         pending_states.push_back(predict_state(f, a, b));
      endfunction

      function void check_result(state_type actual);
         state_type expected;
         if (pending_states.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("result word %0d arrived with no request outstanding", actual);
            end
         end else begin
            expected = pending_states.pop_front();
            if (actual !== expected) begin
               failures++;
               if (failures <= 10) begin
                  $display("result_state mismatch: expected %0d, actual %0d", expected, actual);
               end
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   esge_req_if req_ch ();
   esge_rsp_if rsp_ch ();

   gate_result_tracker tracker;

   eight_state_logic_gate_evaluator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("tb_eight_state_logic_gate_evaluator: done, errors");
      $finish;
   end

   // Entered and left at a falling edge; the word is noted at the edge that accepts it.
   task automatic send_word(input func_type f, input state_type a, input state_type b,
                            input bit steady);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(f, a, b);
      @(negedge clock);
   endtask

   task automatic drain_pause();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (tracker.pending_states.size() != 0);
   endtask

   initial begin
      int cycle_count;
      rsp_ch.ready = 1'b0;
      cycle_count = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         cycle_count++;
         rsp_ch.ready <= (cycle_count >= 1200 && cycle_count < 1700) ||
                         $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_result(rsp_ch.result_state);
      end
   end

   initial begin
      tracker = new();
      req_ch.valid     = 1'b0;
      req_ch.func      = FN_RESOLVE;
      req_ch.operand_a = ST_S0;
      req_ch.operand_b = ST_S0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(FN_RESOLVE,    ST_S1, ST_S0, 1'b0);
      send_word(FN_RESOLVE,    ST_WX, ST_WX, 1'b0);
      send_word(FN_AND,        ST_S0, ST_X,  1'b0);
      send_word(FN_AND,        ST_W1, ST_SX, 1'b0);
      send_word(FN_AND,        ST_S1, ST_S1, 1'b0);
      send_word(FN_OR,         ST_S1, ST_SX, 1'b0);
      send_word(FN_OR,         ST_W0, ST_Z,  1'b0);
      send_word(FN_XOR,        ST_SX, ST_Z,  1'b0);
      send_word(FN_XOR,        ST_Z,  ST_W1, 1'b0);
      send_word(FN_XOR,        ST_W0, ST_W1, 1'b0);
      send_word(FN_XOR,        ST_S1, ST_S0, 1'b0);
      send_word(FN_NAND,       ST_S1, ST_S1, 1'b0);
      send_word(FN_NOR,        ST_W1, ST_WX, 1'b0);
      send_word(FN_XNOR,       ST_X,  ST_S0, 1'b0);
      send_word(FN_NOT,        ST_W0, ST_WX, 1'b0);
      send_word(FN_BUF,        ST_WX, ST_S0, 1'b0);
      send_word(FN_WEAKPULL,   ST_Z,  ST_S1, 1'b0);
      send_word(FN_WEAKPULLDN, ST_Z,  ST_S0, 1'b0);
      send_word(FN_STRONGPULL, ST_Z,  ST_X,  1'b0);
      send_word(FN_STRONGPULL, ST_WX, ST_S0, 1'b0);
      send_word(FN_VCC,        ST_S0, ST_WX, 1'b0);
      send_word(FN_GND,        ST_WX, ST_WX, 1'b0);
      send_word(FN_TRISTATE,   ST_WX, ST_W1, 1'b0);
      send_word(FN_TRISTATE,   ST_S1, ST_WX, 1'b0);
      send_word(FN_TRISTATE,   ST_S1, ST_SX, 1'b0);
      send_word(FN_UNUSED,     ST_S0, ST_S0, 1'b0);
      drain_pause();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 1100) begin
            drain_pause();
         end
         send_word(func_type'($urandom_range(15)), state_type'($urandom_range(7)),
                   state_type'($urandom_range(7)), i >= 700 && i < 1000);
      end
      req_ch.valid <= 1'b0;

      while (tracker.pending_states.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_states.size() == 0) begin
         $display("tb_eight_state_logic_gate_evaluator: done, clean");
      end else begin
         $display("tb_eight_state_logic_gate_evaluator: done, errors");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/esge_pkg.sv
rtl/esge_if.sv
rtl/esge_eval.sv
rtl/eight_state_logic_gate_evaluator.sv
verif/tb_eight_state_logic_gate_evaluator.sv
